FILE: hdl/ngga_pkg.sv
// ----------------------------------------------------------------------------
// ngga_pkg
// Shared types and constants of the GGA sentence parser.
// ----------------------------------------------------------------------------
package ngga_pkg;

	// Fraction digits kept for latitude and longitude (1 to 6)
	localparam int unsigned FRACTION_DIGITS = 4;

	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 88;

	localparam logic [26:0] LAT_MAX = 27'd99999999;
	localparam logic [29:0] LON_MAX = 30'd999999999;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_DOLLAR = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;
	localparam logic [1:0] ST_NOT_GGA  = 2'd3;

	// First member lands in the top bits: status ends up at bit 0
	typedef struct packed {
		logic signed [30:0] longitude_e6;
		logic signed [27:0] latitude_e6;
		logic [6:0]         second;
		logic [6:0]         minute;
		logic [6:0]         hour;
		logic [1:0]         status;
	} ngga_result_t;

endpackage

FILE: hdl/ngga_core.sv
// ----------------------------------------------------------------------------
// ngga_core
// Input register and per-character sentence state; builds one result per line.
// ----------------------------------------------------------------------------
module ngga_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  out_free,
	output logic                  res_vld,
	output ngga_pkg::ngga_result_t res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_JUNK = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	localparam logic [2:0] NUM_STOP = 3'd7;
	localparam logic [2:0] FRAC     = 3'(ngga_pkg::FRACTION_DIGITS);
	localparam logic [1:0] HEX_BAD  = 2'd3;

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = "G";
			3'd1:    c = "P";
			3'd2:    c = "G";
			3'd3:    c = "G";
			3'd4:    c = "A";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [19:0] pow10(input logic [2:0] k);
		logic [19:0] p;
		unique case (k)
			3'd0:    p = 20'd1;
			3'd1:    p = 20'd10;
			3'd2:    p = 20'd100;
			3'd3:    p = 20'd1000;
			3'd4:    p = 20'd10000;
			3'd5:    p = 20'd100000;
			3'd6:    p = 20'd1000000;
			default: p = 20'd1;
		endcase
		return p;
	endfunction

	// Input register
	logic [7:0] char_s1;
	logic       vld_s1;

	// Sentence state
	logic [1:0]       phase_q;
	logic [7:0]       xor_q, rsum_q;
	logic [1:0]       hexcnt_q;
	logic [2:0]       hidx_q;
	logic             hmis_q;
	logic [3:0]       fidx_q;
	logic             fchar_q;
	logic             fseen_q;
	logic [2:0]       fdig_q;
	logic [5:0][3:0]  tdig_q;
	logic [26:0]      lat_q;
	logic [29:0]      lon_q;
	logic             south_q, west_q;

	logic [1:0]       phase_d;
	logic [7:0]       xor_d, rsum_d;
	logic [1:0]       hexcnt_d;
	logic [2:0]       hidx_d;
	logic             hmis_d;
	logic [3:0]       fidx_d;
	logic             fchar_d;
	logic             fseen_d;
	logic [2:0]       fdig_d;
	logic [5:0][3:0]  tdig_d;
	logic [26:0]      lat_d;
	logic [29:0]      lon_d;
	logic             south_d, west_d;

	logic       eol, is_digit, emit_cond, s1_go;
	logic [3:0] dval;
	logic       hex_ok;
	logic [3:0] hex_v;
	logic [1:0] status_c;

	// Shared arithmetic for the current lat/lon field
	logic        num_lat;
	logic [29:0] num_acc, num_max, push_res, scale_res;
	logic [33:0] push_sum;
	logic [49:0] scale_prod;

	assign eol       = (char_s1 == 8'd13) || (char_s1 == 8'd10);
	assign is_digit  = (char_s1 >= "0") && (char_s1 <= "9");
	assign dval      = 4'(char_s1 - "0");
	assign emit_cond = eol && (phase_q != PH_IDLE);
	assign s1_go     = vld_s1 && (!emit_cond || out_free);
	assign s_tready  = !vld_s1 || s1_go;

	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		if (is_digit) begin
			hex_v = dval;
		end else if (char_s1 >= "A" && char_s1 <= "F") begin
			hex_v = 4'(char_s1 - "A" + 8'd10);
		end else if (char_s1 >= "a" && char_s1 <= "f") begin
			hex_v = 4'(char_s1 - "a" + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign num_lat  = (fidx_q == 4'd2);
	assign num_acc  = num_lat ? {3'd0, lat_q} : lon_q;
	assign num_max  = num_lat ? {3'd0, ngga_pkg::LAT_MAX} : ngga_pkg::LON_MAX;
	assign push_sum = ({4'd0, num_acc} << 3) + ({4'd0, num_acc} << 1) + 34'(dval);
	assign push_res = (push_sum > 34'(num_max)) ? num_max : push_sum[29:0];
	assign scale_prod = 50'(num_acc) * 50'(pow10(3'(FRAC - fdig_q)));
	assign scale_res  = (scale_prod > 50'(num_max)) ? num_max : scale_prod[29:0];

	always_comb begin
		logic fin;
		logic push;
		phase_d  = phase_q;
		xor_d    = xor_q;
		rsum_d   = rsum_q;
		hexcnt_d = hexcnt_q;
		hidx_d   = hidx_q;
		hmis_d   = hmis_q;
		fidx_d   = fidx_q;
		fchar_d  = fchar_q;
		fseen_d  = fseen_q;
		fdig_d   = fdig_q;
		tdig_d   = tdig_q;
		lat_d    = lat_q;
		lon_d    = lon_q;
		south_d  = south_q;
		west_d   = west_q;
		fin      = 1'b0;
		push     = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (char_s1 == "$") begin
					phase_d  = PH_BODY;
					xor_d    = 8'd0;
					rsum_d   = 8'd0;
					hexcnt_d = 2'd0;
					hidx_d   = 3'd0;
					hmis_d   = 1'b0;
					fidx_d   = 4'd0;
					fchar_d  = 1'b0;
					fseen_d  = 1'b0;
					fdig_d   = 3'd0;
					tdig_d   = '0;
					lat_d    = '0;
					lon_d    = '0;
					south_d  = 1'b0;
					west_d   = 1'b0;
				end else if (!eol) begin
					phase_d = PH_JUNK;
				end
			end
			PH_JUNK: begin
				if (eol) phase_d = PH_IDLE;
			end
			PH_BODY: begin
				if (eol) begin
					phase_d = PH_IDLE;
				end else if (char_s1 == "*") begin
					if (hidx_q < 3'd5) hmis_d = 1'b1;
					fin     = (hidx_q == 3'd6) && (fidx_q == 4'd2 || fidx_q == 4'd4);
					phase_d = PH_SUM;
				end else begin
					xor_d = xor_q ^ char_s1;
					if (hidx_q < 3'd5) begin
						if (char_s1 != hdr_char(hidx_q)) hmis_d = 1'b1;
						hidx_d = hidx_q + 3'd1;
					end else if (hidx_q == 3'd5) begin
						if (char_s1 != ",") hmis_d = 1'b1;
						hidx_d  = 3'd6;
						fidx_d  = 4'd1;
						fchar_d = 1'b0;
						fseen_d = 1'b0;
						fdig_d  = 3'd0;
					end else if (char_s1 == ",") begin
						fin = (fidx_q == 4'd2) || (fidx_q == 4'd4);
						if (fidx_q != 4'd15) fidx_d = fidx_q + 4'd1;
						fchar_d = 1'b0;
						fseen_d = 1'b0;
						fdig_d  = 3'd0;
					end else begin
						// Character inside a field
						fchar_d = 1'b1;
						if (fidx_q == 4'd3) begin
							south_d = !fchar_q && (char_s1 == "S");
						end else if (fidx_q == 4'd5) begin
							west_d = !fchar_q && (char_s1 == "W");
						end else if ((fidx_q == 4'd1 || fidx_q == 4'd2 || fidx_q == 4'd4)
							&& fdig_q != NUM_STOP) begin
							if (is_digit) begin
								if (fidx_q == 4'd1) begin
									if (!fseen_q) tdig_d = {tdig_q[4:0], dval};
								end else if (!fseen_q) begin
									push = 1'b1;
								end else if (fdig_q < FRAC) begin
									fdig_d = fdig_q + 3'd1;
									push   = 1'b1;
								end
							end else if (char_s1 == "." && !fseen_q) begin
								fseen_d = 1'b1;
							end else begin
								fin = 1'b1;
							end
						end
					end
				end
			end
			PH_SUM: begin
				if (eol) begin
					phase_d = PH_IDLE;
				end else if (hexcnt_q < 2'd2 && hex_ok) begin
					rsum_d   = {rsum_q[3:0], hex_v};
					hexcnt_d = hexcnt_q + 2'd1;
				end else begin
					hexcnt_d = HEX_BAD;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		// Pad to the fixed fraction width, then stop the number
		if (fin) begin
			if (fdig_q <= FRAC && (fidx_q == 4'd2 || fidx_q == 4'd4)) begin
				if (num_lat) lat_d = scale_res[26:0];
				else lon_d = scale_res;
			end
			if (fidx_d == fidx_q && phase_d == PH_BODY && char_s1 != ",") fdig_d = NUM_STOP;
		end
		if (push) begin
			if (num_lat) lat_d = push_res[26:0];
			else lon_d = push_res;
		end
	end

	always_comb begin
		if (phase_q != PH_SUM) begin
			status_c = (phase_q == PH_JUNK) ? ngga_pkg::ST_NO_DOLLAR : ngga_pkg::ST_CHECKSUM;
		end else if (hexcnt_q != 2'd2 || rsum_q != xor_q) begin
			status_c = ngga_pkg::ST_CHECKSUM;
		end else if (hmis_q) begin
			status_c = ngga_pkg::ST_NOT_GGA;
		end else begin
			status_c = ngga_pkg::ST_OK;
		end
	end

	always_comb begin
		logic ok;
		ok = (status_c == ngga_pkg::ST_OK);
		res.status       = status_c;
		res.hour         = ok ? 7'({tdig_q[5], 3'd0} + {tdig_q[5], 1'b0} + tdig_q[4]) : 7'd0;
		res.minute       = ok ? 7'({tdig_q[3], 3'd0} + {tdig_q[3], 1'b0} + tdig_q[2]) : 7'd0;
		res.second       = ok ? 7'({tdig_q[1], 3'd0} + {tdig_q[1], 1'b0} + tdig_q[0]) : 7'd0;
		res.latitude_e6  = !ok ? 28'sd0 :
			south_q ? -$signed({1'b0, lat_q}) : $signed({1'b0, lat_q});
		res.longitude_e6 = !ok ? 31'sd0 :
			west_q ? -$signed({1'b0, lon_q}) : $signed({1'b0, lon_q});
	end

	assign res_vld = vld_s1 && emit_cond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) char_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			xor_q    <= '0;
			rsum_q   <= '0;
			hexcnt_q <= '0;
			hidx_q   <= '0;
			hmis_q   <= 1'b0;
			fidx_q   <= '0;
			fchar_q  <= 1'b0;
			fseen_q  <= 1'b0;
			fdig_q   <= '0;
			tdig_q   <= '0;
			lat_q    <= '0;
			lon_q    <= '0;
			south_q  <= 1'b0;
			west_q   <= 1'b0;
		end else if (s1_go) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			rsum_q   <= rsum_d;
			hexcnt_q <= hexcnt_d;
			hidx_q   <= hidx_d;
			hmis_q   <= hmis_d;
			fidx_q   <= fidx_d;
			fchar_q  <= fchar_d;
			fseen_q  <= fseen_d;
			fdig_q   <= fdig_d;
			tdig_q   <= tdig_d;
			lat_q    <= lat_d;
			lon_q    <= lon_d;
			south_q  <= south_d;
			west_q   <= west_d;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_go |=> $stable(phase_q) && $stable(lat_q) && $stable(char_s1))
		else $error("sentence state moved while the character was stalled");

	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && emit_cond |=> phase_q == PH_IDLE)
		else $error("line end did not return the parser to idle");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld && res.status != ngga_pkg::ST_OK |->
		res.hour == 7'd0 && res.latitude_e6 == 28'sd0 && res.longitude_e6 == 31'sd0)
		else $error("failed sentence carries non-zero fields");

endmodule

FILE: hdl/ngga_out_reg.sv
// ----------------------------------------------------------------------------
// ngga_out_reg
// Result register holding one item until the sink takes it.
// ----------------------------------------------------------------------------
module ngga_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  ngga_pkg::ngga_result_t in_res,
	output logic                   free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output ngga_pkg::ngga_result_t res_q
);

	logic vld_q;

	assign free     = !vld_q || m_tready;
	assign m_tvalid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (free && in_vld) res_q <= in_res;
	end

endmodule

FILE: hdl/nmea_gga_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// Checks and decodes GGA sentences fed one character per item.
// ----------------------------------------------------------------------------
// Path: a line-end character is taken into the input register, and its result
//   then into the result register, which drives m_tvalid.
// Throughput: one character per cycle; the parser stalls only while a finished
//   result waits in the result register and the next character ends a line.
// Reset: arst_n clears the parser to idle (waiting for a leading dollar) and
//   empties both registers.
module nmea_gga_sentence_parser (
	input  logic        clk,
	input  logic        arst_n,
	// Character stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	// Result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // [1:0] status, [8:2] hour, [15:9] minute,
	                               // [22:16] second, [50:23] latitude_e6,
	                               // [81:51] longitude_e6, [87:82] zero
);

	ngga_pkg::ngga_result_t core_res, out_res;
	logic core_vld, out_free;

	// Parse each character against the running sentence state
	ngga_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.out_free (out_free),
		.res_vld  (core_vld),
		.res      (core_res)
	);

	// Hold the finished item so the parser keeps taking characters
	ngga_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (core_vld),
		.in_res   (core_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_q    (out_res)
	);

	// Pack fields from the lowest bit up, zero fill to whole bytes
	assign m_tdata = ngga_pkg::M_TDATA_W'(out_res);

endmodule
